// ===== sv/pcmcia_card_access_decoder_unit_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef PCMCIA_CARD_ACCESS_DECODER_UNIT_MACROS_SVH
`define PCMCIA_CARD_ACCESS_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcad assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcad assertion failed");

`endif

// ===== sv/pcad_pkg.sv =====
// Package: types, constants and the CIS tuple table of the card access decoder.
`default_nettype none
package pcad_pkg;

    localparam int ADDRESS_BITS = 22;
    localparam int LED_PIXELS   = 7;

    localparam int ADDR_W      = ADDRESS_BITS;
    localparam int DATA_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 32;
    localparam int LED_IDX_W   = 3;
    localparam int LED_SEL_W   = (LED_PIXELS > 1) ? $clog2(LED_PIXELS) : 1;
    localparam int MEM_OP_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = ADDR_W;
    localparam int OFS_W       = 16;

    // I/O register offsets (address bits 15:0)
    localparam logic [OFS_W-1:0] OFS_SPI_DATA = 16'h0200;
    localparam logic [OFS_W-1:0] OFS_SPI_CS   = 16'h0202;
    localparam logic [OFS_W-1:0] OFS_STATUS   = 16'h0204;
    localparam logic [OFS_W-1:0] OFS_BOARD    = 16'h0206;
    localparam logic [OFS_W-1:0] OFS_ID       = 16'h0208;
    localparam logic [OFS_W-1:0] OFS_LED      = 16'h0220;
    localparam logic [OFS_W-1:0] OFS_LED_END  = OFS_W'(32'h0220 + 4 * LED_PIXELS);

    localparam logic [BYTE_W-1:0] BOARD_ID      = 8'h01;
    localparam logic [DATA_W-1:0] IO_UNKNOWN_RD = 16'hFF00;
    localparam logic [BYTE_W-1:0] SPI_IDLE_BYTE = 8'hFF;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0] RST_ROM_LIMIT     = ADDR_W'(32'h0002_0000);
    localparam logic [ADDR_W-1:0] RST_ROM_WORD_MASK = ADDR_W'(32'h0001_FFFE);
    localparam logic [ADDR_W-1:0] RST_IO_SPACE_BASE = ADDR_W'(32'h0022_0000);
    localparam logic [ADDR_W-1:0] RST_IO_REG_BASE   = ADDR_W'(32'h0022_0200);
    localparam logic [ADDR_W-1:0] RST_SRAM_MASK     = ADDR_W'(32'h003F_FFFE);

    // CIS tuple table, one byte per even attribute address
    localparam int CIS_BYTES = 54;
    localparam int CIS_IDX_W = $clog2(CIS_BYTES);
    localparam logic [ADDR_W-1:0] CIS_LIMIT = ADDR_W'(32'h0200);
    localparam logic [BYTE_W-1:0] CIS_PAST_END = 8'hFF;
    localparam logic [BYTE_W-1:0] CIS_TABLE [CIS_BYTES] = '{
        8'h01, 8'h03, 8'hD1, 8'h27, 8'hFF,
        8'h15, 8'h22, 8'h04, 8'h01,
        8'h54, 8'h65, 8'h72, 8'h72, 8'h69, 8'h62, 8'h6C, 8'h65, 8'h46, 8'h69, 8'h72,
        8'h65, 8'h00,
        8'h50, 8'h43, 8'h4D, 8'h43, 8'h49, 8'h41, 8'h20, 8'h53, 8'h44, 8'h2B, 8'h52,
        8'h41, 8'h4D, 8'h00,
        8'h31, 8'h2E, 8'h30, 8'h00,
        8'hFF,
        8'h21, 8'h02, 8'h01, 8'h00,
        8'h91, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
        8'hFF
    };

    typedef enum logic [MEM_OP_W-1:0] {
        MEM_NONE     = 3'd0,
        MEM_ROM_RD   = 3'd1,
        MEM_RAM_RD   = 3'd2,
        MEM_RAM_WR_W = 3'd3,
        MEM_RAM_WR_B = 3'd4
    } t_mem_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_LIMIT     = 3'd0,
        CFG_ROM_WORD_MASK = 3'd1,
        CFG_IO_SPACE_BASE = 3'd2,
        CFG_IO_REG_BASE   = 3'd3,
        CFG_SRAM_MASK     = 3'd4
    } t_cfg_idx;

    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        logic [ADDR_W-1:0] rom_limit;
        logic [ADDR_W-1:0] rom_word_mask;
        logic [ADDR_W-1:0] io_space_base;
        logic [ADDR_W-1:0] io_register_base;
        logic [ADDR_W-1:0] sram_word_mask;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              reg_n;
        logic              oe_n;
        logic              we_n;
        logic              iow_n;
        logic              ior_n;
        logic              uds_n;
        logic              lds_n;
        logic [DATA_W-1:0] write_data;
        logic [BYTE_W-1:0] spi_return_byte;
        logic              card_detect_n;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]    read_data;
        logic                 drive_bus;
        t_mem_op              mem_op;
        logic [ADDR_W-1:0]    mem_address;
        logic [DATA_W-1:0]    mem_write_data;
        logic                 spi_send;
        logic [BYTE_W-1:0]    spi_byte;
        logic                 sd_select_level;
        logic [BYTE_W-1:0]    board_control;
        logic                 led_update;
        logic [LED_IDX_W-1:0] led_index;
        t_pixel               led_pixel;
    } t_result;

    // Current card register state
    typedef struct packed {
        logic [BYTE_W-1:0] board;
        logic [BYTE_W-1:0] spi_last;
        logic              sel;
    } t_state;

    // Register writes caused by one word
    typedef struct packed {
        logic                 board_we;
        logic [BYTE_W-1:0]    board_val;
        logic                 spi_we;
        logic [BYTE_W-1:0]    spi_val;
        logic                 sel_we;
        logic                 sel_val;
        logic                 led_we;
        logic [LED_SEL_W-1:0] led_sel;
        t_pixel               led_val;
    } t_upd;

    // CIS byte on the upper lane for an attribute read
    function automatic logic [DATA_W-1:0] cis_word(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] mask
    );
        logic [ADDR_W-1:0] ofs;
        logic [8:0]        idx;
        logic [BYTE_W-1:0] cis_b;
        ofs   = addr & mask;
        idx   = ofs[9:1];
        cis_b = CIS_PAST_END;
        if (idx < 9'(CIS_BYTES)) begin
            cis_b = CIS_TABLE[idx[CIS_IDX_W-1:0]];
        end
        if (ofs >= CIS_LIMIT) begin
            return '0;
        end
        return {cis_b, 8'h00};
    endfunction

endpackage
`default_nettype wire

// ===== sv/pcad_item_if.sv =====
// Interface: input channel carrying one settled card bus access.
`default_nettype none
interface pcad_item_if;
    logic                          valid;
    logic                          ready;
    logic [pcad_pkg::ADDR_W-1:0]   address;
    logic                          reg_n;
    logic                          oe_n;
    logic                          we_n;
    logic                          iow_n;
    logic                          ior_n;
    logic                          uds_n;
    logic                          lds_n;
    logic [pcad_pkg::DATA_W-1:0]   write_data;
    logic [pcad_pkg::BYTE_W-1:0]   spi_return_byte;
    logic                          card_detect_n;

    modport source (
        output valid, address, reg_n, oe_n, we_n, iow_n, ior_n, uds_n, lds_n,
               write_data, spi_return_byte, card_detect_n,
        input  ready
    );
    modport sink (
        input  valid, address, reg_n, oe_n, we_n, iow_n, ior_n, uds_n, lds_n,
               write_data, spi_return_byte, card_detect_n,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/pcad_result_if.sv =====
// Interface: output channel carrying one decoder result word.
`default_nettype none
interface pcad_result_if;
    logic                           valid;
    logic                           ready;
    logic [pcad_pkg::DATA_W-1:0]    read_data;
    logic                           drive_bus;
    logic [pcad_pkg::MEM_OP_W-1:0]  mem_op;
    logic [pcad_pkg::ADDR_W-1:0]    mem_address;
    logic [pcad_pkg::DATA_W-1:0]    mem_write_data;
    logic                           spi_send;
    logic [pcad_pkg::BYTE_W-1:0]    spi_byte;
    logic                           sd_select_level;
    logic [pcad_pkg::BYTE_W-1:0]    board_control;
    logic                           led_update;
    logic [pcad_pkg::LED_IDX_W-1:0] led_index;
    logic [pcad_pkg::PIXEL_W-1:0]   led_pixel;

    modport source (
        output valid, read_data, drive_bus, mem_op, mem_address, mem_write_data,
               spi_send, spi_byte, sd_select_level, board_control, led_update,
               led_index, led_pixel,
        input  ready
    );
    modport sink (
        input  valid, read_data, drive_bus, mem_op, mem_address, mem_write_data,
               spi_send, spi_byte, sd_select_level, board_control, led_update,
               led_index, led_pixel,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/pcmcia_card_access_decoder_unit.sv =====
// Top level of the card access decoder: input register, decode, result register.
//
// Each word on i_in is one settled card bus access (address, REG, OE, WE, IOW,
// IOR, UDS, LDS, host data, the byte the SD link returns and the card detect
// pin). It answers with exactly one word on o_res: a word to drive on the data
// bus (drive_bus with mem_op none), a request to the external boot ROM or SPI
// RAM, or neither, plus the register side effects: SPI byte out, chip select
// level, board control and LED pixel updates. Attribute accesses below
// io_space_base are answered from the built-in CIS tuple table on the upper
// byte lane whenever a data strobe is active. A word is taken into the input
// register, decoded combinationally and lands in the result register once
// that slot is free, which raises o_res.valid; one word per cycle is sustained
// while o_res.ready stays high. The result register lets a new word in while
// the previous result still waits for o_res.ready; with both registers full
// the input stalls until o_res.ready returns. Register state is updated as a
// word moves into the result register, so the next word already sees it.
// Configuration writes on i_cfg_* take effect at the next edge and are meant to
// be issued while no word is in flight.
`default_nettype none
module pcmcia_card_access_decoder_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pcad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pcad_item_if.sink                              i_in,
    pcad_result_if.source                          o_res
);
    pcad_pkg::t_cfg    cfg;
    pcad_pkg::t_state  state;
    pcad_pkg::t_pixel  led [pcad_pkg::LED_PIXELS];
    pcad_pkg::t_result dec_result;
    pcad_pkg::t_upd    dec_upd;

    pcad_pkg::t_item   r_item;
    pcad_pkg::t_item   n_item;
    logic              r_item_vld;
    pcad_pkg::t_result r_res;
    logic              r_res_vld;

    logic              res_free;
    logic              item_move;
    logic              in_fire;

    // result slot frees when empty or being taken this cycle
    assign res_free  = !r_res_vld || o_res.ready;
    assign item_move = r_item_vld && res_free;
    assign in_fire   = i_in.valid && i_in.ready;

    // take a new word whenever the input slot is empty or draining
    assign i_in.ready = !r_item_vld || res_free;

    always_comb begin
        n_item.address         = i_in.address;
        n_item.reg_n           = i_in.reg_n;
        n_item.oe_n            = i_in.oe_n;
        n_item.we_n            = i_in.we_n;
        n_item.iow_n           = i_in.iow_n;
        n_item.ior_n           = i_in.ior_n;
        n_item.uds_n           = i_in.uds_n;
        n_item.lds_n           = i_in.lds_n;
        n_item.write_data      = i_in.write_data;
        n_item.spi_return_byte = i_in.spi_return_byte;
        n_item.card_detect_n   = i_in.card_detect_n;
    end

    pcad_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcad_decode u_dec (
        .i_item   (r_item),
        .i_cfg    (cfg),
        .i_state  (state),
        .i_led    (led),
        .o_result (dec_result),
        .o_upd    (dec_upd)
    );

    // commit register effects only when the word advances
    pcad_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (item_move),
        .i_upd   (dec_upd),
        .o_state (state),
        .o_led   (led)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_item_vld <= 1'b1;
            end else if (item_move) begin
                r_item_vld <= 1'b0;
            end
            if (item_move) begin
                r_res_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // payload registers: load on handshake, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= n_item;
        end
        if (item_move) begin
            r_res <= dec_result;
        end
    end

    assign o_res.valid           = r_res_vld;
    assign o_res.read_data       = r_res.read_data;
    assign o_res.drive_bus       = r_res.drive_bus;
    assign o_res.mem_op          = r_res.mem_op;
    assign o_res.mem_address     = r_res.mem_address;
    assign o_res.mem_write_data  = r_res.mem_write_data;
    assign o_res.spi_send        = r_res.spi_send;
    assign o_res.spi_byte        = r_res.spi_byte;
    assign o_res.sd_select_level = r_res.sd_select_level;
    assign o_res.board_control   = r_res.board_control;
    assign o_res.led_update      = r_res.led_update;
    assign o_res.led_index       = r_res.led_index;
    assign o_res.led_pixel       = r_res.led_pixel;
endmodule
`default_nettype wire

// ===== sv/pcad_cfg_regs.sv =====
// Configuration registers of the card access decoder.
`default_nettype none
module pcad_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pcad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pcad_pkg::t_cfg                         o_cfg
);
    pcad_pkg::t_cfg r_cfg;
    pcad_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (pcad_pkg::t_cfg_idx'(i_cfg_index))
                pcad_pkg::CFG_ROM_LIMIT:     n_cfg.rom_limit        = i_cfg_data;
                pcad_pkg::CFG_ROM_WORD_MASK: n_cfg.rom_word_mask    = i_cfg_data;
                pcad_pkg::CFG_IO_SPACE_BASE: n_cfg.io_space_base    = i_cfg_data;
                pcad_pkg::CFG_IO_REG_BASE:   n_cfg.io_register_base = i_cfg_data;
                pcad_pkg::CFG_SRAM_MASK:     n_cfg.sram_word_mask   = i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_limit        <= pcad_pkg::RST_ROM_LIMIT;
            r_cfg.rom_word_mask    <= pcad_pkg::RST_ROM_WORD_MASK;
            r_cfg.io_space_base    <= pcad_pkg::RST_IO_SPACE_BASE;
            r_cfg.io_register_base <= pcad_pkg::RST_IO_REG_BASE;
            r_cfg.sram_word_mask   <= pcad_pkg::RST_SRAM_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== sv/pcad_state.sv =====
// Card register state: board control, SPI return byte, chip select, LED store.
`default_nettype none
module pcad_state (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  pcad_pkg::t_upd      i_upd,
    output pcad_pkg::t_state    o_state,
    output pcad_pkg::t_pixel    o_led [pcad_pkg::LED_PIXELS]
);
    pcad_pkg::t_state r_state;
    pcad_pkg::t_pixel r_led [pcad_pkg::LED_PIXELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.board    <= '0;
            r_state.spi_last <= pcad_pkg::SPI_IDLE_BYTE;
            r_state.sel      <= 1'b1;
        end else if (i_en) begin
            if (i_upd.board_we) begin
                r_state.board <= i_upd.board_val;
            end
            if (i_upd.spi_we) begin
                r_state.spi_last <= i_upd.spi_val;
            end
            if (i_upd.sel_we) begin
                r_state.sel <= i_upd.sel_val;
            end
        end
    end

    for (genvar g = 0; g < pcad_pkg::LED_PIXELS; g++) begin : g_led
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_led[g] <= '0;
            end else if (i_en && i_upd.led_we &&
                         (i_upd.led_sel == pcad_pkg::LED_SEL_W'(g))) begin
                r_led[g] <= i_upd.led_val;
            end
        end
        assign o_led[g] = r_led[g];
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== sv/pcad_decode.sv =====
// Access decode: one registered bus word to its result and register writes.
`default_nettype none
module pcad_decode (
    input  pcad_pkg::t_item     i_item,
    input  pcad_pkg::t_cfg      i_cfg,
    input  pcad_pkg::t_state    i_state,
    input  pcad_pkg::t_pixel    i_led [pcad_pkg::LED_PIXELS],
    output pcad_pkg::t_result   o_result,
    output pcad_pkg::t_upd      o_upd
);
    logic [pcad_pkg::OFS_W-1:0]     ofs;
    logic [pcad_pkg::OFS_W-1:0]     led_diff;
    logic                           led_hit;
    logic [pcad_pkg::LED_SEL_W-1:0] led_sel;
    pcad_pkg::t_pixel               led_old;
    logic [pcad_pkg::BYTE_W-1:0]    wr_byte;
    logic [pcad_pkg::DATA_W-1:0]    io_rd;
    logic [pcad_pkg::DATA_W-1:0]    cis_rd;
    logic                           io_reg_hit;

    assign ofs        = i_item.address[pcad_pkg::OFS_W-1:0];
    assign led_diff   = ofs - pcad_pkg::OFS_LED;
    assign led_hit    = (ofs >= pcad_pkg::OFS_LED) && (ofs < pcad_pkg::OFS_LED_END);
    assign led_sel    = led_diff[pcad_pkg::LED_SEL_W+1:2];
    assign led_old    = i_led[led_sel];
    assign wr_byte    = i_item.write_data[15:8];
    assign cis_rd     = pcad_pkg::cis_word(i_item.address, i_cfg.rom_word_mask);
    assign io_reg_hit = i_item.address >= i_cfg.io_register_base;

    always_comb begin
        unique case (ofs)
            pcad_pkg::OFS_SPI_DATA: io_rd = {i_state.spi_last, 8'h00};
            pcad_pkg::OFS_SPI_CS:   io_rd = {7'd0, i_state.sel, 8'h00};
            pcad_pkg::OFS_STATUS:   io_rd = {7'd0, !i_item.card_detect_n, 8'h00};
            pcad_pkg::OFS_BOARD:    io_rd = {i_state.board, 8'h00};
            pcad_pkg::OFS_ID:       io_rd = {pcad_pkg::BOARD_ID, 8'h00};
            default:                io_rd = pcad_pkg::IO_UNKNOWN_RD;
        endcase
    end

    always_comb begin
        o_result        = '0;
        o_result.mem_op = pcad_pkg::MEM_NONE;
        o_upd           = '0;

        if (i_item.uds_n && i_item.lds_n) begin
            // no data strobe: bus floats
        end else if (!i_item.reg_n && (i_item.address < i_cfg.io_space_base)) begin
            o_result.drive_bus = 1'b1;
            o_result.read_data = cis_rd;
        end else if (!i_item.oe_n) begin
            o_result.drive_bus = 1'b1;
            if (!i_item.reg_n) begin
                o_result.read_data = cis_rd;
            end else if (i_item.address < i_cfg.rom_limit) begin
                o_result.mem_op      = pcad_pkg::MEM_ROM_RD;
                o_result.mem_address = i_item.address & i_cfg.rom_word_mask;
            end else begin
                o_result.mem_op      = pcad_pkg::MEM_RAM_RD;
                o_result.mem_address = i_item.address & i_cfg.sram_word_mask;
            end
        end else if (!i_item.we_n) begin
            priority if (!i_item.uds_n && !i_item.lds_n) begin
                o_result.mem_op         = pcad_pkg::MEM_RAM_WR_W;
                o_result.mem_address    = i_item.address;
                o_result.mem_write_data = i_item.write_data;
            end else if (!i_item.uds_n) begin
                o_result.mem_op         = pcad_pkg::MEM_RAM_WR_B;
                o_result.mem_address    = i_item.address;
                o_result.mem_write_data = {8'h00, wr_byte};
            end else begin
                o_result.mem_op         = pcad_pkg::MEM_RAM_WR_B;
                o_result.mem_address    = i_item.address | pcad_pkg::ADDR_W'(1);
                o_result.mem_write_data = {8'h00, i_item.write_data[7:0]};
            end
        end else if (!i_item.iow_n) begin
            if (io_reg_hit) begin
                priority if (led_hit) begin
                    o_upd.led_we  = 1'b1;
                    o_upd.led_sel = led_sel;
                    if (!led_diff[1]) begin
                        o_upd.led_val = {i_item.write_data, led_old[15:0]};
                    end else begin
                        o_upd.led_val = {led_old[31:16], i_item.write_data};
                    end
                    o_result.led_update = 1'b1;
                    o_result.led_index  = pcad_pkg::LED_IDX_W'(led_sel);
                    o_result.led_pixel  = o_upd.led_val;
                end else if (ofs == pcad_pkg::OFS_BOARD) begin
                    o_upd.board_we  = 1'b1;
                    o_upd.board_val = wr_byte;
                end else if (ofs == pcad_pkg::OFS_SPI_DATA) begin
                    o_result.spi_send = 1'b1;
                    o_result.spi_byte = wr_byte;
                    o_upd.spi_we      = 1'b1;
                    o_upd.spi_val     = i_item.spi_return_byte;
                end else if (ofs == pcad_pkg::OFS_SPI_CS) begin
                    o_upd.board_we = 1'b1;
                    o_upd.sel_we   = 1'b1;
                    o_upd.sel_val  = wr_byte[0];
                end else begin
                    // unknown write offset: ignore
                end
            end
        end else if (!i_item.ior_n) begin
            o_result.drive_bus = 1'b1;
            if (io_reg_hit) begin
                o_result.read_data = io_rd;
            end else if (!i_item.reg_n) begin
                o_result.read_data = cis_rd;
            end else begin
                o_result.mem_op      = pcad_pkg::MEM_ROM_RD;
                o_result.mem_address = i_item.address & i_cfg.rom_word_mask;
            end
        end

        // report register levels as they stand after this word
        o_result.sd_select_level = o_upd.sel_we   ? o_upd.sel_val   : i_state.sel;
        o_result.board_control   = o_upd.board_we ? o_upd.board_val : i_state.board;
    end
endmodule
`default_nettype wire

// ===== sv/pcad_checker.sv =====
// Port-level checker of the card access decoder, bound to the top level.
`default_nettype none
`include "pcmcia_card_access_decoder_unit_macros.svh"
module pcad_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [pcad_pkg::DATA_W-1:0]    i_out_read_data,
    input wire logic [pcad_pkg::MEM_OP_W-1:0]  i_out_mem_op
);
    logic in_fire;
    logic out_stall;

    assign in_fire   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // an empty result slot never blocks the input
    `PCAD_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // an accepted word has a result waiting once it has passed the input and result registers
    `PCAD_ASSERT_IMPL(a_result_latency, i_clk, i_rst_n, in_fire, ##2 i_out_valid)

    // a stalled result holds
    `PCAD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_stall,
                      i_out_valid && $stable(i_out_read_data) && $stable(i_out_mem_op))

    // memory requests never carry an internal read word
    `PCAD_ASSERT_IMPL(a_req_no_data, i_clk, i_rst_n,
                      i_out_valid && (i_out_mem_op != pcad_pkg::MEM_NONE), i_out_read_data == '0)
endmodule

bind pcmcia_card_access_decoder_unit pcad_checker u_pcad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_read_data (o_res.read_data),
    .i_out_mem_op    (o_res.mem_op)
);
`default_nettype wire

// ===== sim/pcmcia_card_access_decoder_unit_test.sv =====
// Testbench for the card access decoder: directed and random bus accesses checked against a predictor.
`default_nettype none
module pcmcia_card_access_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Card register offsets, address bits 15:0
    localparam logic [15:0] IO_SD_DATA   = 16'h0200;
    localparam logic [15:0] IO_SD_SELECT = 16'h0202;
    localparam logic [15:0] REG_STATUS   = 16'h0204;
    localparam logic [15:0] REG_BOARD    = 16'h0206;
    localparam logic [15:0] REG_ID       = 16'h0208;
    localparam logic [15:0] REG_LED      = 16'h0220;
    localparam int          LED_COUNT    = 7;
    localparam logic [15:0] REG_LED_END  = 16'(16'h0220 + 4 * LED_COUNT);

    localparam logic [7:0]  BOARD_ID_BYTE   = 8'h01;
    localparam logic [15:0] UNKNOWN_IO_WORD = 16'hFF00;
    localparam logic [21:0] ATTR_LIMIT      = 22'h000200;
    localparam int          ATTR_COUNT      = 54;

    // Attribute tuple bytes, first byte in the top lane
    localparam logic [ATTR_COUNT*8-1:0] ATTR_TUPLES = {
        8'h01, 8'h03, 8'hD1, 8'h27, 8'hFF,
        8'h15, 8'h22, 8'h04, 8'h01,
        8'h54, 8'h65, 8'h72, 8'h72, 8'h69, 8'h62, 8'h6C, 8'h65, 8'h46, 8'h69, 8'h72,
        8'h65, 8'h00,
        8'h50, 8'h43, 8'h4D, 8'h43, 8'h49, 8'h41, 8'h20, 8'h53, 8'h44, 8'h2B, 8'h52,
        8'h41, 8'h4D, 8'h00,
        8'h31, 8'h2E, 8'h30, 8'h00,
        8'hFF,
        8'h21, 8'h02, 8'h01, 8'h00,
        8'h91, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
        8'hFF
    };

    localparam pcad_pkg::t_cfg RESET_SETTINGS = '{
        rom_limit:        22'h020000,
        rom_word_mask:    22'h01FFFE,
        io_space_base:    22'h220000,
        io_register_base: 22'h220200,
        sram_word_mask:   22'h3FFFFE
    };

    // Access strobes as {oe_n, we_n, iow_n, ior_n}; bit position is priority
    localparam logic [3:0] ACC_OE   = 4'b0111;
    localparam logic [3:0] ACC_WE   = 4'b1011;
    localparam logic [3:0] ACC_IOW  = 4'b1101;
    localparam logic [3:0] ACC_IOR  = 4'b1110;
    localparam logic [3:0] ACC_NONE = 4'b1111;
    localparam int         POS_IOR  = 0;
    localparam int         POS_IOW  = 1;
    localparam int         POS_WE   = 2;
    localparam int         POS_OE   = 3;
    localparam int         POS_NONE = 4;

    // Data strobes as {uds_n, lds_n}
    localparam logic [1:0] DS_WORD  = 2'b00;
    localparam logic [1:0] DS_UPPER = 2'b01;
    localparam logic [1:0] DS_LOWER = 2'b10;
    localparam logic [1:0] DS_OFF   = 2'b11;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF_LEN  = 60;
    localparam int PHASE_WORDS   = 33;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [pcad_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pcad_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pcad_item_if   access_ch ();
    pcad_result_if response_ch ();

    pcmcia_card_access_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (access_ch),
        .o_res       (response_ch)
    );

    // Predicted card state: configuration, registers and LED store
    pcad_pkg::t_cfg decode_cfg;
    logic [7:0]  board_ctl_q;
    logic [7:0]  spi_return_q;
    logic        cs_level_q;
    logic [31:0] led_pixels_q [LED_COUNT];

    pcad_pkg::t_result awaited_responses [$];
    int          mismatch_count;
    int          responses_seen;
    int          source_idle_pct;
    int          sink_stall_pct;
    int          hold_off_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case a word is lost or the handshake hangs
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: count down a forced hold-off first, else stall at the phase's rate
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            response_ch.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            response_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("response %0d %s: got %h, expected %h",
                                      responses_seen, name, got, want));
        end
    endtask

    // Check every accepted response against the oldest prediction
    always @(posedge i_clk) begin : check_responses
        pcad_pkg::t_result want;
        if (i_rst_n && response_ch.valid && response_ch.ready) begin
            responses_seen++;
            if (awaited_responses.size() == 0) begin
                report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                          responses_seen));
            end else begin
                want = awaited_responses.pop_front();
                compare_field("read_data", 32'(response_ch.read_data), 32'(want.read_data));
                compare_field("drive_bus", 32'(response_ch.drive_bus), 32'(want.drive_bus));
                compare_field("mem_op", 32'(response_ch.mem_op), 32'(want.mem_op));
                compare_field("mem_address", 32'(response_ch.mem_address),
                              32'(want.mem_address));
                compare_field("mem_write_data", 32'(response_ch.mem_write_data),
                              32'(want.mem_write_data));
                compare_field("spi_send", 32'(response_ch.spi_send), 32'(want.spi_send));
                compare_field("spi_byte", 32'(response_ch.spi_byte), 32'(want.spi_byte));
                compare_field("sd_select_level", 32'(response_ch.sd_select_level),
                              32'(want.sd_select_level));
                compare_field("board_control", 32'(response_ch.board_control),
                              32'(want.board_control));
                compare_field("led_update", 32'(response_ch.led_update),
                              32'(want.led_update));
                compare_field("led_index", 32'(response_ch.led_index), 32'(want.led_index));
                compare_field("led_pixel", response_ch.led_pixel, want.led_pixel);
            end
        end
    end

    // Tuple byte for an attribute read, on the upper lane
    function automatic logic [15:0] attr_tuple_word(input logic [21:0] addr);
        logic [21:0] ofs;
        int          idx;
        ofs = addr & decode_cfg.rom_word_mask;
        if (ofs >= ATTR_LIMIT) begin
            return 16'h0000;
        end
        idx = int'(ofs[9:1]);
        if (idx < ATTR_COUNT) begin
            return {ATTR_TUPLES[(ATTR_COUNT - 1 - idx) * 8 +: 8], 8'h00};
        end
        return 16'hFF00;
    endfunction

    // Decode one access the way the card should, updating the predicted state
    function automatic pcad_pkg::t_result decode_bus_access(input pcad_pkg::t_item a);
        pcad_pkg::t_result r;
        logic [15:0] ofs;
        logic [15:0] led_word;
        logic [2:0]  pix;
        r = '0;
        r.mem_op = pcad_pkg::MEM_NONE;
        ofs = a.address[15:0];
        if (!(a.uds_n && a.lds_n)) begin
            if (!a.reg_n && a.address < decode_cfg.io_space_base) begin
                // attribute space below the I/O window answers whatever the strobes
                r.drive_bus = 1'b1;
                r.read_data = attr_tuple_word(a.address);
            end else if (!a.oe_n) begin
                r.drive_bus = 1'b1;
                if (!a.reg_n) begin
                    r.read_data = attr_tuple_word(a.address);
                end else if (a.address < decode_cfg.rom_limit) begin
                    r.mem_op      = pcad_pkg::MEM_ROM_RD;
                    r.mem_address = a.address & decode_cfg.rom_word_mask;
                end else begin
                    r.mem_op      = pcad_pkg::MEM_RAM_RD;
                    r.mem_address = a.address & decode_cfg.sram_word_mask;
                end
            end else if (!a.we_n) begin
                r.mem_address = a.address;
                if (!a.uds_n && !a.lds_n) begin
                    r.mem_op         = pcad_pkg::MEM_RAM_WR_W;
                    r.mem_write_data = a.write_data;
                end else if (!a.uds_n) begin
                    r.mem_op         = pcad_pkg::MEM_RAM_WR_B;
                    r.mem_write_data = {8'h00, a.write_data[15:8]};
                end else begin
                    r.mem_op         = pcad_pkg::MEM_RAM_WR_B;
                    r.mem_address    = a.address | 22'h000001;
                    r.mem_write_data = {8'h00, a.write_data[7:0]};
                end
            end else if (!a.iow_n) begin
                if (a.address >= decode_cfg.io_register_base) begin
                    if (ofs >= REG_LED && ofs < REG_LED_END) begin
                        // even word sets the top half of the pixel, odd word the bottom
                        led_word = (ofs - REG_LED) >> 1;
                        pix      = led_word[3:1];
                        if (!led_word[0]) begin
                            led_pixels_q[pix][31:16] = a.write_data;
                        end else begin
                            led_pixels_q[pix][15:0] = a.write_data;
                        end
                        r.led_update = 1'b1;
                        r.led_index  = pix;
                        r.led_pixel  = led_pixels_q[pix];
                    end else if (ofs == REG_BOARD) begin
                        board_ctl_q = a.write_data[15:8];
                    end else if (ofs == IO_SD_DATA) begin
                        r.spi_send   = 1'b1;
                        r.spi_byte   = a.write_data[15:8];
                        spi_return_q = a.spi_return_byte;
                    end else if (ofs == IO_SD_SELECT) begin
                        board_ctl_q = 8'h00;
                        cs_level_q  = a.write_data[8];
                    end
                end
            end else if (!a.ior_n) begin
                r.drive_bus = 1'b1;
                if (a.address >= decode_cfg.io_register_base) begin
                    case (ofs)
                        IO_SD_DATA:   r.read_data = {spi_return_q, 8'h00};
                        IO_SD_SELECT: r.read_data = {7'b0, cs_level_q, 8'h00};
                        REG_STATUS:   r.read_data = {7'b0, ~a.card_detect_n, 8'h00};
                        REG_BOARD:    r.read_data = {board_ctl_q, 8'h00};
                        REG_ID:       r.read_data = {BOARD_ID_BYTE, 8'h00};
                        default:      r.read_data = UNKNOWN_IO_WORD;
                    endcase
                end else if (!a.reg_n) begin
                    r.read_data = attr_tuple_word(a.address);
                end else begin
                    r.mem_op      = pcad_pkg::MEM_ROM_RD;
                    r.mem_address = a.address & decode_cfg.rom_word_mask;
                end
            end
        end
        r.sd_select_level = cs_level_q;
        r.board_control   = board_ctl_q;
        return r;
    endfunction

    function automatic pcad_pkg::t_item make_access(input logic [21:0] addr,
                                          input logic reg_n,
                                          input logic [3:0] acc_n, input logic [1:0] ds_n,
                                          input logic [15:0] data, input logic [7:0] ret,
                                          input logic cd_n);
        pcad_pkg::t_item a;
        a.address = addr;
        a.reg_n   = reg_n;
        {a.oe_n, a.we_n, a.iow_n, a.ior_n} = acc_n;
        {a.uds_n, a.lds_n} = ds_n;
        a.write_data      = data;
        a.spi_return_byte = ret;
        a.card_detect_n   = cd_n;
        return a;
    endfunction

    // Random access, weighted toward well-formed accesses in each address region
    function automatic pcad_pkg::t_item random_access();
        pcad_pkg::t_item a;
        int unsigned kind;
        int          pos;
        logic [3:0]  acc;
        logic [15:0] ofs;
        logic [5:0]  hi;
        logic [21:0] bound;
        a.address         = 22'($urandom);
        a.reg_n           = 1'($urandom);
        a.write_data      = 16'($urandom);
        a.spi_return_byte = 8'($urandom);
        a.card_detect_n   = 1'($urandom);
        {a.oe_n, a.we_n, a.iow_n, a.ior_n, a.uds_n, a.lds_n} = 6'($urandom);
        kind = $urandom_range(99);
        pos  = $urandom_range(POS_IOR, POS_NONE);
        if (kind < 20) begin
            // attribute tuple space
            a.reg_n = 1'b0;
            if ($urandom_range(3) == 0 && decode_cfg.io_space_base != '0) begin
                a.address = 22'($urandom_range(0, int'(decode_cfg.io_space_base) - 1));
            end else begin
                a.address = 22'($urandom_range(0, 16'h03FF));
            end
        end else if (kind < 45) begin
            // card registers: known offsets, LED store, its borders and noise
            case ($urandom_range(0, 9))
                0: ofs = IO_SD_DATA;
                1: ofs = IO_SD_SELECT;
                2: ofs = REG_STATUS;
                3: ofs = REG_BOARD;
                4: ofs = REG_ID;
                8: ofs = REG_LED_END + 16'($urandom_range(0, 1)) - 16'($urandom_range(0, 1) * 4);
                9: ofs = 16'($urandom);
                default: ofs = REG_LED + 16'($urandom_range(0, 4 * LED_COUNT - 1));
            endcase
            hi = 6'($urandom_range(int'(decode_cfg.io_register_base[21:16]), 63));
            a.address = {hi, ofs};
            pos = $urandom_range(POS_IOR, POS_IOW);
        end else if (kind < 65) begin
            // common memory reads and writes; writes land in either space
            a.reg_n = ($urandom_range(3) != 0);
            pos = $urandom_range(POS_WE, POS_OE);
        end else if (kind < 80) begin
            // one step around a configured boundary
            case ($urandom_range(0, 2))
                0: bound = decode_cfg.rom_limit;
                1: bound = decode_cfg.io_space_base;
                default: bound = decode_cfg.io_register_base;
            endcase
            a.address = bound + 22'($urandom_range(0, 2)) - 22'h000001;
        end
        if (kind < 80) begin
            // drop the chosen strobe, raise higher priority ones, leave lower ones random
            acc = 4'($urandom);
            if (pos == POS_NONE) begin
                acc = ACC_NONE;
            end else begin
                for (int j = pos + 1; j < 4; j++) begin
                    acc[j] = 1'b1;
                end
                acc[pos] = 1'b0;
            end
            {a.oe_n, a.we_n, a.iow_n, a.ior_n} = acc;
            if ($urandom_range(9) == 0) begin
                {a.uds_n, a.lds_n} = DS_OFF;
            end else begin
                {a.uds_n, a.lds_n} = 2'($urandom_range(0, 2));
            end
        end
        return a;
    endfunction

    // Offer one word after a random gap; predict it once it is taken
    task automatic drive_access(input pcad_pkg::t_item acc);
        @(negedge i_clk);
        while ($urandom_range(99) < source_idle_pct) begin
            access_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        access_ch.valid           <= 1'b1;
        access_ch.address         <= acc.address;
        access_ch.reg_n           <= acc.reg_n;
        access_ch.oe_n            <= acc.oe_n;
        access_ch.we_n            <= acc.we_n;
        access_ch.iow_n           <= acc.iow_n;
        access_ch.ior_n           <= acc.ior_n;
        access_ch.uds_n           <= acc.uds_n;
        access_ch.lds_n           <= acc.lds_n;
        access_ch.write_data      <= acc.write_data;
        access_ch.spi_return_byte <= acc.spi_return_byte;
        access_ch.card_detect_n   <= acc.card_detect_n;
        do @(posedge i_clk); while (!access_ch.ready);
        awaited_responses.push_back(decode_bus_access(acc));
    endtask

    // Drop valid, wait for every predicted response, then let the pipe empty
    task automatic settle_block();
        @(negedge i_clk);
        access_ch.valid <= 1'b0;
        while (awaited_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input pcad_pkg::t_cfg_idx idx, input logic [21:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            pcad_pkg::CFG_ROM_LIMIT:     decode_cfg.rom_limit        = val;
            pcad_pkg::CFG_ROM_WORD_MASK: decode_cfg.rom_word_mask    = val;
            pcad_pkg::CFG_IO_SPACE_BASE: decode_cfg.io_space_base    = val;
            pcad_pkg::CFG_IO_REG_BASE:   decode_cfg.io_register_base = val;
            pcad_pkg::CFG_SRAM_MASK:     decode_cfg.sram_word_mask   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Load one full register setting: reset values, all zeros, all ones or random
    task automatic load_settings(input int which);
        pcad_pkg::t_cfg s;
        case (which)
            0: s = RESET_SETTINGS;
            1: s = '0;
            2: s = '1;
            default: begin
                s.rom_limit        = 22'($urandom);
                s.rom_word_mask    = 22'($urandom);
                s.io_space_base    = 22'($urandom);
                s.io_register_base = 22'($urandom);
                s.sram_word_mask   = 22'($urandom);
            end
        endcase
        write_register(pcad_pkg::CFG_ROM_LIMIT, s.rom_limit);
        write_register(pcad_pkg::CFG_ROM_WORD_MASK, s.rom_word_mask);
        write_register(pcad_pkg::CFG_IO_SPACE_BASE, s.io_space_base);
        write_register(pcad_pkg::CFG_IO_REG_BASE, s.io_register_base);
        write_register(pcad_pkg::CFG_SRAM_MASK, s.sram_word_mask);
    endtask

    // Tuple reads: table ends, past the table, beyond the tuple window, no data strobe
    task automatic test_cis_reads();
        drive_access(make_access(22'h000000, 1'b0, ACC_OE, DS_OFF, 16'hFFFF, 8'hFF, 1'b0));
        drive_access(make_access(22'h000000, 1'b0, ACC_OE, DS_UPPER, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h00006A, 1'b0, ACC_OE, DS_LOWER, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h00006C, 1'b0, ACC_IOR, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h21FFFF, 1'b0, ACC_WE, DS_WORD, 16'hFFFF, 8'hFF, 1'b1));
        drive_access(make_access(22'h000002, 1'b0, ACC_NONE, DS_WORD, 16'h0000, 8'h00, 1'b1));
    endtask

    // ROM and RAM requests: masking, word writes and both byte lanes
    task automatic test_memory_requests();
        drive_access(make_access(22'h01FFFF, 1'b1, ACC_OE, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h3FFFFF, 1'b1, ACC_OE, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h3FFFFF, 1'b1, ACC_WE, DS_WORD, 16'hFFFF, 8'h00, 1'b1));
        drive_access(make_access(22'h123456, 1'b1, ACC_WE, DS_UPPER, 16'hA55A, 8'h00, 1'b1));
        drive_access(make_access(22'h000000, 1'b1, ACC_WE, DS_LOWER, 16'hA55A, 8'h00, 1'b1));
        drive_access(make_access(22'h000000, 1'b1, ACC_NONE, DS_WORD, 16'h0000, 8'h00, 1'b1));
    endtask

    // SPI data, chip select, board control, status, ID and unknown offsets
    task automatic test_io_registers();
        drive_access(make_access(22'h220200, 1'b1, ACC_IOW, DS_WORD, 16'hC300, 8'h3C, 1'b1));
        drive_access(make_access(22'h220200, 1'b1, ACC_IOR, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h3F0206, 1'b1, ACC_IOW, DS_UPPER, 16'hFF00, 8'h00, 1'b1));
        drive_access(make_access(22'h220202, 1'b1, ACC_IOW, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h220204, 1'b1, ACC_IOR, DS_WORD, 16'h0000, 8'h00, 1'b0));
        drive_access(make_access(22'h220208, 1'b0, ACC_IOR, DS_LOWER, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h22FFFF, 1'b1, ACC_IOR, DS_WORD, 16'h0000, 8'h00, 1'b1));
        drive_access(make_access(22'h2201FE, 1'b1, ACC_IOW, DS_WORD, 16'h1234, 8'h00, 1'b1));
    endtask

    // LED store: both halves of the first pixel, the last pixel, one past the end
    task automatic test_led_store();
        drive_access(make_access(22'h220220, 1'b1, ACC_IOW, DS_WORD, 16'h1234, 8'h00, 1'b1));
        drive_access(make_access(22'h220222, 1'b1, ACC_IOW, DS_WORD, 16'h5678, 8'h00, 1'b1));
        drive_access(make_access(22'h22023B, 1'b1, ACC_IOW, DS_WORD, 16'hFFFF, 8'h00, 1'b1));
        drive_access(make_access(22'h22023C, 1'b1, ACC_IOW, DS_WORD, 16'hFFFF, 8'h00, 1'b1));
    endtask

    // Hold the receiver off while words keep coming so the block fills and stalls
    task automatic test_backpressure();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_off_left   = HOLD_OFF_LEN;
        repeat (24) drive_access(random_access());
        // pause the sender until every response is back, then a second burst
        settle_block();
        sink_stall_pct = 84;
        repeat (24) drive_access(random_access());
        settle_block();
    endtask

    // Random traffic over four register settings and four idle patterns each
    task automatic test_random_traffic();
        for (int phase = 0; phase < 16; phase++) begin
            settle_block();
            load_settings(phase / 4);
            case (phase % 4)
                0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin source_idle_pct = 84; sink_stall_pct = 0;  end
                2: begin source_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin source_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            repeat (PHASE_WORDS) drive_access(random_access());
        end
    endtask

    initial begin
        // hold every input at a known value from time zero
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_index               = pcad_pkg::CFG_ROM_LIMIT;
        i_cfg_data                = '0;
        access_ch.valid           = 1'b0;
        access_ch.address         = '0;
        access_ch.reg_n           = 1'b1;
        access_ch.oe_n            = 1'b1;
        access_ch.we_n            = 1'b1;
        access_ch.iow_n           = 1'b1;
        access_ch.ior_n           = 1'b1;
        access_ch.uds_n           = 1'b1;
        access_ch.lds_n           = 1'b1;
        access_ch.write_data      = '0;
        access_ch.spi_return_byte = '0;
        access_ch.card_detect_n   = 1'b1;
        response_ch.ready         = 1'b0;
        mismatch_count            = 0;
        responses_seen            = 0;
        source_idle_pct           = 0;
        sink_stall_pct            = 0;
        hold_off_left             = 0;

        // predicted state after reset
        decode_cfg   = RESET_SETTINGS;
        board_ctl_q  = 8'h00;
        spi_return_q = 8'hFF;
        cs_level_q   = 1'b1;
        for (int p = 0; p < LED_COUNT; p++) begin
            led_pixels_q[p] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cis_reads();
        test_memory_requests();
        test_io_registers();
        test_led_store();
        settle_block();
        test_backpressure();
        test_random_traffic();

        // wait out the tail so a stray extra response still gets caught
        settle_block();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== pcmcia_card_access_decoder_unit.f =====
+incdir+sv
sv/pcad_pkg.sv
sv/pcad_item_if.sv
sv/pcad_result_if.sv
sv/pcad_cfg_regs.sv
sv/pcad_state.sv
sv/pcad_decode.sv
sv/pcmcia_card_access_decoder_unit.sv
sv/pcad_checker.sv
sim/pcmcia_card_access_decoder_unit_test.sv
